FILE: design/spm_pkg.sv
// ----------------------------------------------------------------------------
// Syscall policy monitor package
// Types and codes shared by the syscall policy monitor.
// ----------------------------------------------------------------------------
package spm_pkg;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_EVAL
  } state_t;

  typedef enum logic [1:0] {
    REQ_SYSCALL = 2'd0,
    REQ_EXIT    = 2'd1,
    REQ_LIMIT   = 2'd2,
    REQ_TRANS   = 2'd3
  } req_t;

  localparam logic [1:0] KIND_NONE  = 2'd0;
  localparam logic [1:0] KIND_COUNT = 2'd1;
  localparam logic [1:0] KIND_TRANS = 2'd2;

  localparam int CFG_ADDR_W = 1;
  localparam logic [CFG_ADDR_W-1:0] CFG_CTRL_PID = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] CFG_TGT_PID  = 1'b1;

  localparam int NR_W      = 9;
  localparam int SLOT_IN_W = 10;
  localparam int ID_W      = 32;
  localparam int CNT_W     = 32;
  localparam int WORD_W    = 64;
  localparam int BIT_W     = 6;
  localparam int IN_DATA_W  = 128;
  localparam int OUT_DATA_W = 152;
  localparam int OUT_USER_W = 3;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  typedef struct packed {
    logic            valid;
    logic [NR_W-1:0] call;
  } thr_entry_t;

  typedef struct packed {
    logic             lim_valid;
    logic [CNT_W-1:0] limit;
    logic [CNT_W-1:0] count;
  } sys_entry_t;

endpackage

FILE: design/syscall_policy_monitor.sv
// ----------------------------------------------------------------------------
// Syscall policy monitor
// Per-syscall call limits and allowed transitions between a thread's calls.
// ----------------------------------------------------------------------------
// An item passes through IDLE, READ and EVAL: the accept cycle reads the thread,
// syscall and transition tables, READ reads the transition word of the previous
// call, and EVAL writes back and registers the result. A result not yet taken
// holds EVAL. One item at a time: the next item is accepted only after EVAL has
// handed on its result. After reset a clearing pass zeroes the thread, syscall
// and transition tables before the first item is taken.
module syscall_policy_monitor #(
  parameter int THREAD_SLOTS = 1024,
  parameter int NUM_SYSCALLS = 512
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // pid, tid, thread_slot, call_nr, from_nr, limit_in, enable
  input  logic [spm_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // req_type
  input  logic [1:0]                     s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // kill, viol_pid, viol_tid, viol_syscall, prev_syscall, viol_count, viol_limit
  output logic [spm_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  // violation, kind
  output logic [spm_pkg::OUT_USER_W-1:0] m_axis_tuser,
  input  logic                           cfg_we,
  input  logic [spm_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [spm_pkg::ID_W-1:0]       cfg_wdata
);

  localparam int SLOT_W      = $clog2(THREAD_SLOTS);
  localparam int SYS_W       = $clog2(NUM_SYSCALLS);
  localparam int PAIR_W      = $clog2(NUM_SYSCALLS * NUM_SYSCALLS);
  localparam int AW_W        = PAIR_W - spm_pkg::BIT_W;
  localparam int ALLOW_WORDS = (NUM_SYSCALLS * NUM_SYSCALLS + 63) / 64;
  localparam int CLR_DEPTH_A = (THREAD_SLOTS > NUM_SYSCALLS) ? THREAD_SLOTS : NUM_SYSCALLS;
  localparam int CLR_DEPTH   = (CLR_DEPTH_A > ALLOW_WORDS) ? CLR_DEPTH_A : ALLOW_WORDS;
  localparam int CLR_W       = $clog2(CLR_DEPTH + 1);

  function automatic logic [SYS_W-1:0] sys_idx(input logic [spm_pkg::NR_W-1:0] nr);
    logic [spm_pkg::NR_W-1:0] v;
    v = nr;
    for (int k = 3; k >= 0; k--) begin
      if ({23'b0, v} >= (32'(NUM_SYSCALLS) << k)) begin
        v = v - spm_pkg::NR_W'(32'(NUM_SYSCALLS) << k);
      end
    end
    return SYS_W'(v);
  endfunction

  function automatic logic [SLOT_W-1:0] slot_idx(input logic [spm_pkg::SLOT_IN_W-1:0] s);
    logic [spm_pkg::SLOT_IN_W-1:0] v;
    v = s;
    for (int k = 5; k >= 0; k--) begin
      if ({22'b0, v} >= (32'(THREAD_SLOTS) << k)) begin
        v = v - spm_pkg::SLOT_IN_W'(32'(THREAD_SLOTS) << k);
      end
    end
    return SLOT_W'(v);
  endfunction

  function automatic logic [PAIR_W-1:0] pair_of(input logic [spm_pkg::NR_W-1:0] from_nr,
                                                input logic [spm_pkg::NR_W-1:0] to_nr);
    logic [PAIR_W-1:0] p;
    p = PAIR_W'(PAIR_W'(sys_idx(from_nr)) * PAIR_W'(NUM_SYSCALLS)) + PAIR_W'(sys_idx(to_nr));
    return p;
  endfunction

  // Input fields.
  logic [spm_pkg::ID_W-1:0]      in_pid;
  logic [spm_pkg::ID_W-1:0]      in_tid;
  logic [spm_pkg::SLOT_IN_W-1:0] in_slot;
  logic [spm_pkg::NR_W-1:0]      in_nr;
  logic [spm_pkg::NR_W-1:0]      in_from;
  logic [spm_pkg::CNT_W-1:0]     in_limit;
  logic                          in_enable;
  logic [PAIR_W-1:0]             in_pair;

  assign in_pid    = s_axis_tdata[31:0];
  assign in_tid    = s_axis_tdata[63:32];
  assign in_slot   = s_axis_tdata[73:64];
  assign in_nr     = s_axis_tdata[82:74];
  assign in_from   = s_axis_tdata[91:83];
  assign in_limit  = s_axis_tdata[123:92];
  assign in_enable = s_axis_tdata[124];
  assign in_pair   = pair_of(in_from, in_nr);

  spm_pkg::state_t state;
  spm_pkg::state_t state_next;
  logic [CLR_W-1:0] clr_cnt;

  logic [spm_pkg::ID_W-1:0] ctrl_pid;
  logic [spm_pkg::ID_W-1:0] tgt_pid;

  // Captured item.
  spm_pkg::req_t             req;
  logic [spm_pkg::ID_W-1:0]  pid;
  logic [spm_pkg::ID_W-1:0]  tid;
  logic [SLOT_W-1:0]         slot;
  logic [spm_pkg::NR_W-1:0]  nr;
  logic [SYS_W-1:0]          sidx;
  logic [spm_pkg::CNT_W-1:0] limit_in;
  logic                      enable;
  logic [AW_W-1:0]           a_word;
  logic [spm_pkg::BIT_W-1:0] a_bit;

  // Memories and their read data.
  spm_pkg::thr_entry_t thr_mem [THREAD_SLOTS];
  spm_pkg::sys_entry_t sys_mem [NUM_SYSCALLS];
  logic [spm_pkg::WORD_W-1:0] allow_mem [ALLOW_WORDS];

  spm_pkg::thr_entry_t        thr_rd;
  spm_pkg::sys_entry_t        sys_rd;
  logic [spm_pkg::WORD_W-1:0] allow_rd;

  logic                       accept;
  logic                       go;
  logic                       allow_re;
  logic [AW_W-1:0]            allow_raddr;
  logic [PAIR_W-1:0]          prev_pair;

  logic                       thr_we;
  logic [SLOT_W-1:0]          thr_waddr;
  spm_pkg::thr_entry_t        thr_wdata;
  logic                       sys_we;
  logic [SYS_W-1:0]           sys_waddr;
  spm_pkg::sys_entry_t        sys_wdata;
  logic                       allow_we;
  logic [AW_W-1:0]            allow_waddr;
  logic [spm_pkg::WORD_W-1:0] allow_wdata;

  logic                       live;
  logic [spm_pkg::CNT_W-1:0]  cnt_inc;
  logic                       res_viol;
  logic [1:0]                 res_kind;
  logic                       res_kill;
  logic [spm_pkg::CNT_W-1:0]  res_count;
  logic [spm_pkg::CNT_W-1:0]  res_limit;

  logic                            out_valid;
  logic [spm_pkg::OUT_DATA_W-1:0]  out_data;
  logic [spm_pkg::OUT_USER_W-1:0]  out_user;

  assign accept    = s_axis_tvalid && s_axis_tready;
  assign prev_pair = pair_of(thr_rd.call, nr);

  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl_pid <= '0;
      tgt_pid  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        spm_pkg::CFG_CTRL_PID: ctrl_pid <= cfg_wdata;
        spm_pkg::CFG_TGT_PID:  tgt_pid  <= cfg_wdata;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= spm_pkg::ST_CLEAR;
      clr_cnt <= '0;
    end else begin
      state <= state_next;
      if (state == spm_pkg::ST_CLEAR) begin
        clr_cnt <= clr_cnt + CLR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req      <= spm_pkg::req_t'(s_axis_tuser);
      pid      <= in_pid;
      tid      <= in_tid;
      slot     <= slot_idx(in_slot);
      nr       <= in_nr;
      sidx     <= sys_idx(in_nr);
      limit_in <= in_limit;
      enable   <= in_enable;
      a_word   <= in_pair[PAIR_W-1:spm_pkg::BIT_W];
      a_bit    <= in_pair[spm_pkg::BIT_W-1:0];
    end else if (state == spm_pkg::ST_READ && req == spm_pkg::REQ_SYSCALL) begin
      a_word <= prev_pair[PAIR_W-1:spm_pkg::BIT_W];
      a_bit  <= prev_pair[spm_pkg::BIT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (thr_we) begin
      thr_mem[thr_waddr] <= thr_wdata;
    end
    if (accept) begin
      thr_rd <= thr_mem[slot_idx(in_slot)];
    end
  end

  always_ff @(posedge clk) begin
    if (sys_we) begin
      sys_mem[sys_waddr] <= sys_wdata;
    end
    if (accept) begin
      sys_rd <= sys_mem[sys_idx(in_nr)];
    end
  end

  always_ff @(posedge clk) begin
    if (allow_we) begin
      allow_mem[allow_waddr] <= allow_wdata;
    end
    if (allow_re) begin
      allow_rd <= allow_mem[allow_raddr];
    end
  end

  always_comb begin
    state_next  = state;
    s_axis_tready = 1'b0;
    go          = 1'b0;
    allow_re    = 1'b0;
    allow_raddr = in_pair[PAIR_W-1:spm_pkg::BIT_W];
    thr_we      = 1'b0;
    thr_waddr   = slot;
    thr_wdata   = '{valid: 1'b1, call: nr};
    sys_we      = 1'b0;
    sys_waddr   = sidx;
    sys_wdata   = sys_rd;
    allow_we    = 1'b0;
    allow_waddr = a_word;
    allow_wdata = allow_rd;
    live        = (pid == tgt_pid) && (pid != ctrl_pid);
    cnt_inc     = (sys_rd.count == spm_pkg::CNT_MAX) ? sys_rd.count
                                                     : sys_rd.count + spm_pkg::CNT_W'(1);
    res_viol    = 1'b0;
    res_kind    = spm_pkg::KIND_NONE;
    res_kill    = 1'b0;
    res_count   = '0;
    res_limit   = '0;

    unique case (state)
      spm_pkg::ST_CLEAR: begin
        thr_we      = clr_cnt < CLR_W'(THREAD_SLOTS);
        thr_waddr   = clr_cnt[SLOT_W-1:0];
        thr_wdata   = '0;
        sys_we      = clr_cnt < CLR_W'(NUM_SYSCALLS);
        sys_waddr   = clr_cnt[SYS_W-1:0];
        sys_wdata   = '0;
        allow_we    = clr_cnt < CLR_W'(ALLOW_WORDS);
        allow_waddr = clr_cnt[AW_W-1:0];
        allow_wdata = '0;
        if (clr_cnt == CLR_W'(CLR_DEPTH - 1)) begin
          state_next = spm_pkg::ST_IDLE;
        end
      end
      spm_pkg::ST_IDLE: begin
        s_axis_tready = 1'b1;
        allow_re      = s_axis_tvalid;
        if (s_axis_tvalid) begin
          state_next = spm_pkg::ST_READ;
        end
      end
      spm_pkg::ST_READ: begin
        allow_re    = (req == spm_pkg::REQ_SYSCALL);
        allow_raddr = prev_pair[PAIR_W-1:spm_pkg::BIT_W];
        state_next  = spm_pkg::ST_EVAL;
      end
      spm_pkg::ST_EVAL: begin
        go = !out_valid || m_axis_tready;
        if (go) begin
          state_next = spm_pkg::ST_IDLE;
        end
        unique case (req)
          spm_pkg::REQ_SYSCALL: begin
            thr_we          = go && live;
            sys_we          = go && live;
            sys_wdata.count = cnt_inc;
            if (thr_rd.valid) begin
              if (sys_rd.lim_valid && cnt_inc > sys_rd.limit) begin
                res_viol        = live;
                res_kind        = live ? spm_pkg::KIND_COUNT : spm_pkg::KIND_NONE;
                res_kill        = live;
                res_count       = live ? cnt_inc : '0;
                res_limit       = live ? sys_rd.limit : '0;
                thr_wdata.valid = 1'b0;
                sys_wdata.count = '0;
              end else if (!allow_rd[a_bit]) begin
                res_viol        = live;
                res_kind        = live ? spm_pkg::KIND_TRANS : spm_pkg::KIND_NONE;
                sys_wdata.count = '0;
              end
            end
          end
          spm_pkg::REQ_EXIT: begin
            thr_we    = go && (pid == tgt_pid);
            thr_wdata = '{valid: 1'b0, call: nr};
          end
          spm_pkg::REQ_LIMIT: begin
            sys_we              = go;
            sys_wdata.limit     = limit_in;
            sys_wdata.lim_valid = enable;
          end
          spm_pkg::REQ_TRANS: begin
            allow_we           = go;
            allow_wdata[a_bit] = enable;
          end
        endcase
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (go) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      out_user <= {res_kind, res_viol};
      out_data <= {5'b0, res_limit, res_count,
                   res_viol ? thr_rd.call : spm_pkg::NR_W'(0),
                   res_viol ? nr : spm_pkg::NR_W'(0),
                   res_viol ? tid : spm_pkg::ID_W'(0),
                   res_viol ? pid : spm_pkg::ID_W'(0),
                   res_kill};
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;
  assign m_axis_tuser  = out_user;

  a_accept_to_read: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == spm_pkg::ST_READ)
    else $error("accepted item did not start a table read");

  a_quiet_result: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tdata == '0 && m_axis_tuser == '0))
    else $error("result without violation carries non-zero fields");

  a_kill_kind: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tdata[0]) |-> m_axis_tuser[2:1] == spm_pkg::KIND_COUNT)
    else $error("kill requested on a violation other than a count violation");

  a_result_after_eval: assert property (@(posedge clk) disable iff (rst)
    (state == spm_pkg::ST_EVAL && (!m_axis_tvalid || m_axis_tready))
      |=> m_axis_tvalid && state == spm_pkg::ST_IDLE)
    else $error("write-back cycle did not deliver a result");

endmodule
